@@ rtl/core/cidwt_pkg.sv @@
package cidwt_pkg;

  localparam int unsigned SerialW   = 32;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_SUCCESS = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_FULL    = 2'd2,
    ST_PRESENT = 2'd3
  } status_e;

  // which entry the table read port looks at
  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    clear;
    rd_sel_e rd_sel;
    logic    idx_dec;
    logic    idx_inc;
    logic    app_wr;
    logic    shift_wr;
    logic    cnt_dec;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic hit;
    logic idx_zero;
    logic succ_valid;
    logic sh_more;
  } sts_t;

endpackage

@@ rtl/core/cidwt_if.sv @@
interface cidwt_req_if;
  logic                             valid;
  logic                             ready;
  cidwt_pkg::op_e                   op;
  logic [cidwt_pkg::SerialW-1:0]    serial;

  modport source (output valid, output op, output serial, input ready);
  modport sink   (input valid, input op, input serial, output ready);
endinterface

interface cidwt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  cidwt_pkg::status_e               status;
  logic [cidwt_pkg::CountOutW-1:0]  entry_count;

  modport source (output valid, output ok, output status, output entry_count, input ready);
  modport sink   (input valid, input ok, input status, input entry_count, output ready);
endinterface

@@ rtl/core/card_id_whitelist_table.sv @@
// channel  dir  beat payload                     handshake
// req_i    in   op, serial                        valid / ready
// rsp_o    out  ok, status, entry_count           valid / ready
//
// one request at a time; a lookup walks the stored entries top down through the
// single table read port, one entry per cycle
// a delete hit shifts every entry above it down one place (read then write on the table)
// clear and append to a full table finish without a lookup
// reset empties the table at once, no clearing pass; table contents are not reset
// a finished result waits in the output register while the next request is taken
module card_id_whitelist_table #(
  parameter int unsigned MAX_USERS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cidwt_req_if.sink        req_i,
  cidwt_rsp_if.source      rsp_o
);

  cidwt_pkg::cmd_t cmd;
  cidwt_pkg::sts_t sts;

  cidwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cidwt_dp #(
    .MAX_USERS (MAX_USERS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_op_i           (req_i.op),
    .in_serial_i       (req_i.serial),
    .out_ok_o          (rsp_o.ok),
    .out_status_o      (rsp_o.status),
    .out_entry_count_o (rsp_o.entry_count)
  );

endmodule

@@ rtl/core/cidwt_ram.sv @@
module cidwt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/cidwt_dp.sv @@
module cidwt_dp #(
  parameter int unsigned MAX_USERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cidwt_pkg::cmd_t                   cmd_i,
  output cidwt_pkg::sts_t                   sts_o,
  input  cidwt_pkg::op_e                    in_op_i,
  input  logic [cidwt_pkg::SerialW-1:0]     in_serial_i,
  output logic                              out_ok_o,
  output cidwt_pkg::status_e                out_status_o,
  output logic [cidwt_pkg::CountOutW-1:0]   out_entry_count_o
);

  localparam int unsigned AddrW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_USERS + 1);

  logic [CntW-1:0]                     count_q, count_d;
  logic [AddrW-1:0]                    idx_q, idx_d;
  cidwt_pkg::op_e                      op_q;
  logic [cidwt_pkg::SerialW-1:0]       key_q;
  cidwt_pkg::status_e                  status_q;
  logic                                out_ok_q;
  cidwt_pkg::status_e                  out_status_q;
  logic [cidwt_pkg::CountOutW-1:0]     out_cnt_q;

  logic [CntW-1:0]                     cnt_m1;
  logic [CntW:0]                       idx_w, cnt_w;
  logic [CntW+cidwt_pkg::CountOutW-1:0] cnt_ext;
  logic [AddrW-1:0]                    raddr, waddr;
  logic [cidwt_pkg::SerialW-1:0]       wdata, rdata;
  logic                                we;

  assign cnt_m1 = count_q - CntW'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.app_wr) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      // scan starts at the top valid entry
      idx_d = cnt_m1[AddrW-1:0];
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - AddrW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  assign cnt_ext = (CntW + cidwt_pkg::CountOutW)'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      key_q <= in_serial_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_ok_q     <= (status_q == cidwt_pkg::ST_SUCCESS);
      out_status_q <= status_q;
      out_cnt_q    <= cnt_ext[cidwt_pkg::CountOutW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      cidwt_pkg::RD_IDX:  raddr = idx_q;
      // prefetch the next lower entry while comparing this one
      cidwt_pkg::RD_PREV: raddr = (idx_q == '0) ? idx_q : idx_q - AddrW'(1);
      cidwt_pkg::RD_NEXT: raddr = idx_q + AddrW'(1);
      default:            raddr = idx_q;
    endcase
  end

  assign we    = cmd_i.app_wr | cmd_i.shift_wr;
  assign waddr = cmd_i.app_wr ? count_q[AddrW-1:0] : idx_q;
  assign wdata = cmd_i.app_wr ? key_q : rdata;

  cidwt_ram #(
    .Width (cidwt_pkg::SerialW),
    .Depth (MAX_USERS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign idx_w = (CntW + 1)'(idx_q);
  assign cnt_w = (CntW + 1)'(count_q);

  always_comb begin
    sts_o.op         = op_q;
    sts_o.empty      = (count_q == '0);
    sts_o.full       = (count_q == CntW'(MAX_USERS));
    sts_o.hit        = (rdata == key_q);
    sts_o.idx_zero   = (idx_q == '0);
    sts_o.succ_valid = ((idx_w + (CntW + 1)'(1)) < cnt_w);
    sts_o.sh_more    = ((idx_w + (CntW + 1)'(2)) < cnt_w);
  end

  assign out_ok_o          = out_ok_q;
  assign out_status_o      = out_status_q;
  assign out_entry_count_o = out_cnt_q;

endmodule

@@ rtl/core/cidwt_ctrl.sv @@
module cidwt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cidwt_pkg::sts_t  sts_i,
  output cidwt_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DISP    = 9'b000000010,
    S_RD      = 9'b000000100,
    S_CMP     = 9'b000001000,
    S_APPEND  = 9'b000010000,
    S_SH_RD   = 9'b000100000,
    S_SH_WR   = 9'b001000000,
    S_DEL_END = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          cidwt_pkg::OP_CLEAR: begin
            cmd_o.clear      = 1'b1;
            cmd_o.set_status = 1'b1;
            cmd_o.status     = cidwt_pkg::ST_SUCCESS;
            state_d          = S_FIN;
          end
          cidwt_pkg::OP_APPEND: begin
            // full wins over duplicate
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cidwt_pkg::ST_FULL;
              state_d          = S_FIN;
            end else if (sts_i.empty) begin
              state_d = S_APPEND;
            end else begin
              state_d = S_RD;
            end
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cidwt_pkg::ST_ABSENT;
              state_d          = S_FIN;
            end else begin
              state_d = S_RD;
            end
          end
        endcase
      end
      S_RD: begin
        cmd_o.rd_sel = cidwt_pkg::RD_IDX;
        state_d      = S_CMP;
      end
      S_CMP: begin
        cmd_o.rd_sel = cidwt_pkg::RD_PREV;
        if (sts_i.hit) begin
          case (sts_i.op)
            cidwt_pkg::OP_APPEND: begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cidwt_pkg::ST_PRESENT;
              state_d          = S_FIN;
            end
            cidwt_pkg::OP_DELETE: begin
              state_d = sts_i.succ_valid ? S_SH_RD : S_DEL_END;
            end
            default: begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = cidwt_pkg::ST_SUCCESS;
              state_d          = S_FIN;
            end
          endcase
        end else if (sts_i.idx_zero) begin
          if (sts_i.op == cidwt_pkg::OP_APPEND) begin
            state_d = S_APPEND;
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = cidwt_pkg::ST_ABSENT;
            state_d          = S_FIN;
          end
        end else begin
          cmd_o.idx_dec = 1'b1;
        end
      end
      S_APPEND: begin
        cmd_o.app_wr     = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = cidwt_pkg::ST_SUCCESS;
        state_d          = S_FIN;
      end
      S_SH_RD: begin
        cmd_o.rd_sel = cidwt_pkg::RD_NEXT;
        state_d      = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = sts_i.sh_more ? S_SH_RD : S_DEL_END;
      end
      S_DEL_END: begin
        cmd_o.cnt_dec    = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = cidwt_pkg::ST_SUCCESS;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if ((state_q == S_FIN) && can_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ test/cidwt_checker.sv @@
module cidwt_checker #(
  parameter int unsigned MAX_USERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cidwt_req_if        req_i,
  cidwt_rsp_if        rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cidwt_pkg::*;

  typedef struct packed {
    logic                 ok;
    status_e              status;
    logic [CountOutW-1:0] entry_count;
  } outcome_t;

  logic [SerialW-1:0] cards [MAX_USERS];
  int unsigned        card_count = 0;
  outcome_t           outcome_q [$];
  int unsigned        mismatches = 0;
  int unsigned        outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // highest matching slot below the count, -1 when absent
  function automatic int locate_card(logic [SerialW-1:0] serial);
    for (int i = int'(card_count) - 1; i >= 0; i--) begin
      if (cards[i] == serial) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_request(op_e op, logic [SerialW-1:0] serial);
    outcome_t res;
    int       pos;
    res.ok     = 1'b0;
    res.status = ST_ABSENT;
    case (op)
      OP_CHECK: begin
        if (locate_card(serial) >= 0) begin
          res.ok     = 1'b1;
          res.status = ST_SUCCESS;
        end
      end
      OP_APPEND: begin
        // full wins over duplicate
        if (card_count >= MAX_USERS) begin
          res.status = ST_FULL;
        end else if (locate_card(serial) >= 0) begin
          res.status = ST_PRESENT;
        end else begin
          cards[card_count] = serial;
          card_count++;
          res.ok     = 1'b1;
          res.status = ST_SUCCESS;
        end
      end
      OP_DELETE: begin
        pos = locate_card(serial);
        if (pos >= 0) begin
          for (int j = pos; j + 1 < int'(card_count); j++) cards[j] = cards[j+1];
          card_count--;
          cards[card_count] = '0;
          res.ok     = 1'b1;
          res.status = ST_SUCCESS;
        end
      end
      default: begin
        foreach (cards[k]) cards[k] = '0;
        card_count = 0;
        res.ok     = 1'b1;
        res.status = ST_SUCCESS;
      end
    endcase
    res.entry_count = CountOutW'(card_count);
    return res;
  endfunction

  task automatic note_failure(string detail);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, detail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      card_count = 0;
      foreach (cards[k]) cards[k] = '0;
      outcome_q.delete();
      outstanding = 0;
    end else begin
      // a result beat always belongs to an earlier request
      if (rsp_i.valid && rsp_i.ready) begin
        if (outcome_q.size() == 0) begin
          note_failure($sformatf("unexpected result ok=%0b status=%0d entry_count=%0d",
                                 rsp_i.ok, rsp_i.status, rsp_i.entry_count));
        end else begin
          want = outcome_q.pop_front();
          if (rsp_i.ok !== want.ok)
            note_failure($sformatf("ok expected %0b got %0b", want.ok, rsp_i.ok));
          if (rsp_i.status !== want.status)
            note_failure($sformatf("status expected %0d got %0d", want.status, rsp_i.status));
          if (rsp_i.entry_count !== want.entry_count)
            note_failure($sformatf("entry_count expected %0d got %0d",
                                   want.entry_count, rsp_i.entry_count));
        end
      end
      if (req_i.valid && req_i.ready) outcome_q.push_back(apply_request(req_i.op, req_i.serial));
      outstanding = outcome_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cidwt_pkg::*;

  localparam int unsigned MaxUsers    = 16;
  localparam int unsigned RandomItems = 1800;
  localparam int unsigned BlockItems  = 100;
  localparam int unsigned PoolSize    = 20;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_cnt = 0;
  bit          no_gaps = 1'b0;
  bit          hold_rsp = 1'b0;

  logic [SerialW-1:0] card_pool [PoolSize];

  cidwt_req_if req_if ();
  cidwt_rsp_if rsp_if ();

  card_id_whitelist_table #(
    .MAX_USERS (MaxUsers)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  cidwt_checker #(
    .MAX_USERS (MaxUsers)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one beat, wait for it to be taken, then maybe go quiet for a while
  task automatic issue_request(op_e op, logic [SerialW-1:0] serial);
    req_if.valid  <= 1'b1;
    req_if.op     <= op;
    req_if.serial <= serial;
    do @(posedge clk_i); while (!req_if.ready);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  initial begin : rsp_side
    bit hold_done;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rsp && !hold_done) begin
        // long back-pressure while requests keep coming
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (no_gaps || $urandom_range(0, 3) != 0) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    op_e                op;
    logic [SerialW-1:0] serial;
    int unsigned        pick;
    int unsigned        append_weight;
    req_if.valid  <= 1'b0;
    req_if.op     <= OP_CHECK;
    req_if.serial <= '0;
    rst_ni = 1'b0;
    foreach (card_pool[i]) card_pool[i] = $urandom();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, extremes, duplicate, shift on delete, fill up, full, clear
    issue_request(OP_CHECK, 32'h0000_0000);
    issue_request(OP_DELETE, 32'hFFFF_FFFF);
    issue_request(OP_APPEND, 32'h0000_0000);
    issue_request(OP_APPEND, 32'hFFFF_FFFF);
    issue_request(OP_APPEND, 32'hFFFF_FFFF);
    issue_request(OP_CHECK, 32'h0000_0000);
    issue_request(OP_DELETE, 32'h0000_0000);
    issue_request(OP_CHECK, 32'h0000_0000);
    for (int i = 0; i < 15; i++) issue_request(OP_APPEND, 32'h1 << (2 * i + 1));
    issue_request(OP_APPEND, 32'hFFFF_FFFF);
    issue_request(OP_DELETE, 32'hFFFF_FFFF);
    issue_request(OP_CLEAR, 32'h0000_0000);

    for (int blk = 0; blk < RandomItems / BlockItems; blk++) begin
      no_gaps = (blk % 5 == 2) || (blk >= RandomItems / BlockItems - 2);
      if (blk == 6) hold_rsp = 1'b1;
      if (blk == 10) begin
        req_if.valid <= 1'b0;
        // let the checker record the last accepted beat first
        @(posedge clk_i);
        wait (pending_results == 0);
        @(posedge clk_i);
      end
      // fresh serials keep the pool moving; some blocks lean toward a full table
      for (int k = 0; k < 4; k++) card_pool[$urandom_range(0, PoolSize - 1)] = $urandom();
      append_weight = (blk % 2 == 0) ? 65 : 38;
      for (int n = 0; n < BlockItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < append_weight)
          op = OP_APPEND;
        else if (pick < append_weight + (99 - append_weight) / 2)
          op = OP_CHECK;
        else if (pick < 99)
          op = OP_DELETE;
        else
          op = OP_CLEAR;
        if ($urandom_range(0, 9) < 8)
          serial = card_pool[$urandom_range(0, PoolSize - 1)];
        else
          serial = $urandom();
        issue_request(op, serial);
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_results == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
